### hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMP(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");
`define ASSERT_NXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");
`endif

### hw/rtl/aes128_pkg.sv
// Types, tables and helpers for the AES-128 encryption core
`default_nettype none
package aes128_pkg;
	localparam int NROUNDS = 10;
	typedef logic [127:0] blk_t;
	typedef logic [7:0] byte_t;

	localparam byte_t SBOX [0:255] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	localparam byte_t RCON [0:NROUNDS-1] = '{
		8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
	};

	localparam byte_t GF_POLY = 8'h1b;

	function automatic byte_t xtime(input byte_t v);
		return {v[6:0], 1'b0} ^ (v[7] ? GF_POLY : 8'h00);
	endfunction

	function automatic byte_t get_byte(input blk_t b, input int i);
		return b[127 - 8 * i -: 8];
	endfunction
endpackage
`default_nettype wire

### hw/rtl/aes128_block_encrypt_core.sv
// Top level of the pipelined AES-128 encryption core
// AES-128 ECB encryption, one fully unrolled round per pipeline stage. Write the key through the
// APB port (key_upper at 0x0, key_lower at 0x8) while no item is in flight. A plaintext item
// enters every cycle while in_ready is high; its ciphertext leaves after the key addition stage
// and ten round stages of S-box lookups and MixColumns, the last without it. Round keys travel
// with each item through the stages. Stages hold under back-pressure and empty stages close up.
`default_nettype none
`include "assert_macros.svh"
module aes128_block_encrypt_core
	import aes128_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [3:0]  paddr,
	input  wire  [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	input  wire         in_valid,
	output logic        in_ready,
	input  wire  [63:0] plain_upper,
	input  wire  [63:0] plain_lower,
	output logic        out_valid,
	input  wire         out_ready,
	output logic [63:0] cipher_upper,
	output logic [63:0] cipher_lower
);
	localparam int NST = NROUNDS + 1;

	logic [63:0] key_upper_q, key_lower_q;
	blk_t        st_s  [NST];
	blk_t        key_s [NST];
	logic        v_s   [NST];
	logic        rdy   [NST];
	blk_t        nst   [NST];
	blk_t        nkey  [NST];

	assign pready = 1'b1;
	assign prdata = paddr[3] ? key_lower_q : key_upper_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_upper_q <= '0;
			key_lower_q <= '0;
		end else if (psel && penable && pwrite) begin
			if (paddr[3]) begin
				key_lower_q <= pwdata;
			end else begin
				key_upper_q <= pwdata;
			end
		end
	end

	assign nkey[0] = {key_upper_q, key_lower_q};
	assign nst[0]  = {plain_upper, plain_lower} ^ {key_upper_q, key_lower_q};

	for (genvar k = 1; k < NST; k++) begin : g_round
		aes128_round u_round (
			.state      (st_s[k - 1]),
			.key        (key_s[k - 1]),
			.rcon       (RCON[k - 1]),
			.last_round (k == NROUNDS),
			.next_state (nst[k]),
			.next_key   (nkey[k])
		);
	end

	always_comb begin
		rdy[NST - 1] = !v_s[NST - 1] || out_ready;
		for (int k = NST - 2; k >= 0; k--) begin
			rdy[k] = !v_s[k] || rdy[k + 1];
		end
	end

	for (genvar k = 0; k < NST; k++) begin : g_stage
		logic vin;
		if (k == 0) begin : g_first
			assign vin = in_valid;
		end else begin : g_next
			assign vin = v_s[k - 1];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (rdy[k]) begin
				v_s[k] <= vin;
			end
		end
		always_ff @(posedge clk) begin
			if (rdy[k] && vin) begin
				st_s[k]  <= nst[k];
				key_s[k] <= nkey[k];
			end
		end
	end

	assign in_ready     = rdy[0];
	assign out_valid    = v_s[NST - 1];
	assign cipher_upper = st_s[NST - 1][127:64];
	assign cipher_lower = st_s[NST - 1][63:0];

	`ASSERT_NXT(a_enter, clk, arst_n, in_valid && in_ready, v_s[0])
	`ASSERT_IMP(a_empty_ready, clk, arst_n, !out_valid, in_ready)
	`ASSERT_NXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(cipher_upper))
endmodule
`default_nettype wire

### hw/rtl/aes128_round.sv
// One AES round with its key schedule step
`default_nettype none
module aes128_round
	import aes128_pkg::*;
(
	input  wire blk_t  state,
	input  wire blk_t  key,
	input  wire byte_t rcon,
	input  wire logic  last_round,
	output blk_t       next_state,
	output blk_t       next_key
);
	byte_t sh [16];
	byte_t mx [16];
	byte_t rk [16];
	byte_t t  [4];

	always_comb begin
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				sh[r + 4 * c] = SBOX[get_byte(state, r + 4 * ((c + r) & 3))];
			end
		end
		for (int c = 0; c < 4; c++) begin
			byte_t a0, a1, a2, a3, all;
			a0 = sh[4 * c];
			a1 = sh[4 * c + 1];
			a2 = sh[4 * c + 2];
			a3 = sh[4 * c + 3];
			all = a0 ^ a1 ^ a2 ^ a3;
			mx[4 * c]     = last_round ? a0 : a0 ^ all ^ xtime(a0 ^ a1);
			mx[4 * c + 1] = last_round ? a1 : a1 ^ all ^ xtime(a1 ^ a2);
			mx[4 * c + 2] = last_round ? a2 : a2 ^ all ^ xtime(a2 ^ a3);
			mx[4 * c + 3] = last_round ? a3 : a3 ^ all ^ xtime(a3 ^ a0);
		end
		t[0] = SBOX[get_byte(key, 13)] ^ rcon;
		t[1] = SBOX[get_byte(key, 14)];
		t[2] = SBOX[get_byte(key, 15)];
		t[3] = SBOX[get_byte(key, 12)];
		for (int i = 0; i < 4; i++) begin
			rk[i] = get_byte(key, i) ^ t[i];
		end
		for (int i = 4; i < 16; i++) begin
			rk[i] = get_byte(key, i) ^ rk[i - 4];
		end
		for (int i = 0; i < 16; i++) begin
			next_key[127 - 8 * i -: 8]   = rk[i];
			next_state[127 - 8 * i -: 8] = mx[i] ^ rk[i];
		end
	end
endmodule
`default_nettype wire

### sim/tb_aes128_block_encrypt_core.sv
// Testbench for the AES-128 encryption core: directed and random keys and blocks, ciphertext checked
`timescale 1ns / 100ps
`default_nettype none
module tb_aes128_block_encrypt_core;

	localparam logic [3:0] ADDR_KEY_UPPER = 4'h0;
	localparam logic [3:0] ADDR_KEY_LOWER = 4'h8;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct packed {
		logic [63:0] upper;
		logic [63:0] lower;
	} block_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [63:0] pwdata = '0;
	logic [63:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [63:0] plain_upper = '0;
	logic [63:0] plain_lower = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [63:0] cipher_upper;
	logic [63:0] cipher_lower;

	aes128_block_encrypt_core dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready),
		.plain_upper(plain_upper), .plain_lower(plain_lower),
		.out_valid(out_valid), .out_ready(out_ready),
		.cipher_upper(cipher_upper), .cipher_lower(cipher_lower)
	);

	block_t pending_plain[$];
	block_t expected_cipher[$];
	logic [127:0] cipher_key = '0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int errors = 0;
	int quiet_cycles = 0;

	localparam logic [7:0] SUB_BYTE [0:255] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	function automatic logic [7:0] gf_mul2(input logic [7:0] v);
		return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic block_t encrypt_block(input logic [127:0] key, input block_t plain);
		logic [7:0] st [16];
		logic [7:0] rk [16];
		logic [7:0] tmp [16];
		logic [7:0] t [4];
		logic [7:0] rc;
		logic [7:0] a0, a1, a2, a3, all;
		logic [127:0] flat;
		flat = {plain.upper, plain.lower};
		rc = 8'h01;
		for (int i = 0; i < 16; i++) begin
			rk[i] = key[127 - 8 * i -: 8];
			st[i] = flat[127 - 8 * i -: 8] ^ rk[i];
		end
		for (int rnd = 1; rnd <= 10; rnd++) begin
			t[0] = SUB_BYTE[rk[13]] ^ rc;
			t[1] = SUB_BYTE[rk[14]];
			t[2] = SUB_BYTE[rk[15]];
			t[3] = SUB_BYTE[rk[12]];
			rc = gf_mul2(rc);
			for (int i = 0; i < 4; i++)
				rk[i] = rk[i] ^ t[i];
			for (int i = 4; i < 16; i++)
				rk[i] = rk[i] ^ rk[i - 4];
			for (int c = 0; c < 4; c++)
				for (int r = 0; r < 4; r++)
					tmp[r + 4 * c] = SUB_BYTE[st[r + 4 * ((c + r) % 4)]];
			st = tmp;
			if (rnd < 10) begin
				for (int c = 0; c < 4; c++) begin
					a0 = st[4*c]; a1 = st[4*c+1]; a2 = st[4*c+2]; a3 = st[4*c+3];
					all = a0 ^ a1 ^ a2 ^ a3;
					st[4*c]   = a0 ^ all ^ gf_mul2(a0 ^ a1);
					st[4*c+1] = a1 ^ all ^ gf_mul2(a1 ^ a2);
					st[4*c+2] = a2 ^ all ^ gf_mul2(a2 ^ a3);
					st[4*c+3] = a3 ^ all ^ gf_mul2(a3 ^ a0);
				end
			end
			for (int i = 0; i < 16; i++)
				st[i] = st[i] ^ rk[i];
		end
		for (int i = 0; i < 16; i++)
			flat[127 - 8 * i -: 8] = st[i];
		return '{upper: flat[127:64], lower: flat[63:0]};
	endfunction

	initial begin
		forever #2 clk = ~clk;
	end

	// driver
	always @(posedge clk) begin
		block_t nxt;
		if (!(in_valid && !in_ready)) begin
			if (in_valid && in_ready)
				expected_cipher.push_back(encrypt_block(cipher_key,
					'{upper: plain_upper, lower: plain_lower}));
			if (pending_plain.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				nxt = pending_plain.pop_front();
				in_valid <= 1'b1;
				plain_upper <= nxt.upper;
				plain_lower <= nxt.lower;
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// monitor
	always @(posedge clk) begin
		block_t exp_blk;
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (out_valid && out_ready) begin
			if (expected_cipher.size() == 0) begin
				errors = errors + 1;
				$display("%0t: unexpected item upper=%h lower=%h", $time,
					cipher_upper, cipher_lower);
			end else begin
				exp_blk = expected_cipher.pop_front();
				if (cipher_upper !== exp_blk.upper) begin
					errors = errors + 1;
					$display("%0t: cipher_upper expected %h actual %h", $time,
						exp_blk.upper, cipher_upper);
				end
				if (cipher_lower !== exp_blk.lower) begin
					errors = errors + 1;
					$display("%0t: cipher_lower expected %h actual %h", $time,
						exp_blk.lower, cipher_lower);
				end
			end
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic write_reg(input logic [3:0] addr, input logic [63:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == ADDR_KEY_UPPER)
			cipher_key[127:64] = value;
		else
			cipher_key[63:0] = value;
	endtask

	task automatic drain();
		@(negedge clk);
		while (pending_plain.size() > 0 || in_valid || expected_cipher.size() > 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	task automatic queue_random(input int count);
		block_t b;
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(7))
				0: b = '{upper: '0, lower: rand64()};
				1: b = '{upper: rand64(), lower: '1};
				default: b = '{upper: rand64(), lower: rand64()};
			endcase
			pending_plain.push_back(b);
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset key in use before any write
		pending_plain.push_back('{upper: '0, lower: '0});
		pending_plain.push_back('{upper: '1, lower: '1});
		drain();

		write_reg(ADDR_KEY_UPPER, 64'h0001020304050607);
		write_reg(ADDR_KEY_LOWER, 64'h08090a0b0c0d0e0f);
		pending_plain.push_back('{upper: 64'h0011223344556677, lower: 64'h8899aabbccddeeff});
		pending_plain.push_back('{upper: '0, lower: '0});
		pending_plain.push_back('{upper: '1, lower: '1});
		pending_plain.push_back('{upper: 64'h8000000000000000, lower: 64'h1});
		pending_plain.push_back('{upper: 64'h5555555555555555, lower: 64'haaaaaaaaaaaaaaaa});
		drain();

		write_reg(ADDR_KEY_UPPER, '1);
		write_reg(ADDR_KEY_LOWER, '1);
		pending_plain.push_back('{upper: '0, lower: '0});
		pending_plain.push_back('{upper: '1, lower: '1});
		pending_plain.push_back('{upper: 64'haaaaaaaaaaaaaaaa, lower: 64'h5555555555555555});
		drain();

		for (int phase = 0; phase < 8; phase++) begin
			case (phase % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
				default: begin send_idle_pct = 38; recv_stall_pct = 38; end
			endcase
			if (phase == 4)
				write_reg(ADDR_KEY_UPPER, '0);
			else
				write_reg(ADDR_KEY_UPPER, rand64());
			write_reg(ADDR_KEY_LOWER, rand64());
			queue_random(52);
			// add fully random blocks
			for (int i = 0; i < 52; i++)
				pending_plain.push_back('{upper: rand64(), lower: rand64()});
			drain();
		end

		repeat (30) @(posedge clk);
		if (errors == 0 && expected_cipher.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end
endmodule
`default_nettype wire
